// ===== rtl/core/wslc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and reset values for the windowed sound level classifier.
// No dependencies; used by wslc_regs and windowed_sound_level_classifier_core.
package wslc_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 12;
    localparam int THR_BITS    = 12;
    localparam int WIN_BITS    = 8;
    localparam int BIN_BITS    = 8;
    localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    // Configuration port geometry.
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // Reset values of the configuration registers.
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 8'd6;
    localparam logic [THR_BITS-1:0] LOUD_RESET   = 12'd3495;
    localparam logic [THR_BITS-1:0] NOISY_RESET  = 12'd3695;
    localparam logic [THR_BITS-1:0] NORMAL_RESET = 12'd3895;

    // Saturation value of a bin.
    localparam logic [BIN_BITS-1:0] BIN_MAX = {BIN_BITS{1'b1}};

    // Sound levels as reported on the result channel.
    typedef enum logic [1:0] {
        LVL_NORMAL  = 2'd0,
        LVL_NOISY   = 2'd1,
        LVL_LOUD    = 2'd2,
        LVL_SILENCE = 2'd3
    } level_t;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_WINDOW = 2'd0,
        REG_LOUD   = 2'd1,
        REG_NOISY  = 2'd2,
        REG_NORMAL = 2'd3
    } reg_idx_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [WIN_BITS-1:0] window_length;
        logic [THR_BITS-1:0] loud_threshold;
        logic [THR_BITS-1:0] noisy_threshold;
        logic [THR_BITS-1:0] normal_threshold;
    } cfg_t;

endpackage

// ===== rtl/core/windowed_sound_level_classifier_core.sv =====
`timescale 1ns / 1ps
// Top level of the windowed sound level classifier: input register, binning and
// decision logic, result register. Depends on wslc_pkg and wslc_regs.
//
// Usage:
//   Samples enter on the sample channel (sample_valid / sample_ready / sample),
//   one beat per sample. Each sample advances a window counter; when the counter
//   passes window_length the dominant level of the window is emitted as one beat
//   on the result channel (result_valid / result_ready / level, repeated), then
//   the bins are cleared and the current sample is binned. Silence is reported
//   when no bin counted; ties go to the louder level.
//   An accepted sample is held in the input register, and the decision on it
//   is captured in the result register once the result slot is free.
//   Throughput: one sample per cycle while result_ready is high, set by the
//   decision logic between the input register and the result register.
//   Stall: while a result waits for result_ready the input register still takes
//   one sample; further samples are held off until the result is taken.
//   Reset: rst_n clears the counter, bins, last emitted level and both pipeline
//   valids, and loads the default thresholds and window length. The user writes
//   configuration via the APB-style port only while idle; it is not enforced.
module windowed_sound_level_classifier_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wslc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [wslc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [wslc_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic [wslc_pkg::SAMPLE_BITS-1:0] sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [1:0]                       level,
    output logic                             repeated
);
    import wslc_pkg::*;

    cfg_t cfg;

    // Input register.
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    // Block state.
    logic [WIN_BITS-1:0] count_reg, count_next;
    logic [BIN_BITS-1:0] bin_reg [3];
    logic [BIN_BITS-1:0] bin_next [3];
    level_t              last_level_reg;
    logic                last_valid_reg;

    // Result register.
    logic   out_valid_reg;
    level_t out_level_reg;
    logic   out_rep_reg;

    // Datapath signals.
    logic                out_free;
    logic                advance;
    logic [WIN_BITS-1:0] count_inc;
    logic                emit;
    level_t              dom_level;
    logic [BIN_BITS-1:0] dom_count;
    logic                dom_rep;
    logic [CMP_BITS-1:0] s_ext;
    logic [BIN_BITS-1:0] base [3];
    logic                hit [3];

    wslc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the input register moves on whenever the result slot is free.
    assign out_free     = !out_valid_reg || result_ready;
    assign advance      = in_valid_reg && out_free;
    assign sample_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_sample_reg <= sample;
        end
    end

    // Window counter and end-of-window detection.
    assign count_inc = count_reg + 1'b1;
    assign emit      = count_inc > cfg.window_length;

    // Dominant level: a later (louder) bin wins a tie, empty bins never win.
    always_comb
    begin
        dom_level = LVL_SILENCE;
        dom_count = '0;
        if (bin_reg[LVL_NORMAL] != '0)
        begin
            dom_level = LVL_NORMAL;
            dom_count = bin_reg[LVL_NORMAL];
        end
        if (bin_reg[LVL_NOISY] != '0 && bin_reg[LVL_NOISY] >= dom_count)
        begin
            dom_level = LVL_NOISY;
            dom_count = bin_reg[LVL_NOISY];
        end
        if (bin_reg[LVL_LOUD] != '0 && bin_reg[LVL_LOUD] >= dom_count)
        begin
            dom_level = LVL_LOUD;
            dom_count = bin_reg[LVL_LOUD];
        end
    end

    assign dom_rep = last_valid_reg && (last_level_reg == dom_level);

    // Threshold tests in priority order loud, noisy, normal.
    assign s_ext = CMP_BITS'(in_sample_reg);

    always_comb
    begin
        hit[LVL_LOUD]   = s_ext <= CMP_BITS'(cfg.loud_threshold);
        hit[LVL_NOISY]  = !hit[LVL_LOUD] && (s_ext <= CMP_BITS'(cfg.noisy_threshold));
        hit[LVL_NORMAL] = !hit[LVL_LOUD] && !hit[LVL_NOISY]
                          && (s_ext <= CMP_BITS'(cfg.normal_threshold));
    end

    // Next counter and bins: clear at the end of a window, then bin the sample.
    always_comb
    begin
        count_next = emit ? '0 : count_inc;
        for (int i = 0; i < 3; i++)
        begin
            base[i]     = emit ? '0 : bin_reg[i];
            bin_next[i] = (hit[i] && base[i] != BIN_MAX) ? base[i] + 1'b1 : base[i];
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            bin_reg[0]     <= '0;
            bin_reg[1]     <= '0;
            bin_reg[2]     <= '0;
            last_level_reg <= LVL_NORMAL;
            last_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg  <= count_next;
            bin_reg[0] <= bin_next[0];
            bin_reg[1] <= bin_next[1];
            bin_reg[2] <= bin_next[2];
            if (emit)
            begin
                last_level_reg <= dom_level;
                last_valid_reg <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_level_reg <= dom_level;
            out_rep_reg   <= dom_rep;
        end
    end

    assign result_valid = out_valid_reg;
    assign level        = out_level_reg;
    assign repeated     = out_rep_reg;

`ifndef NO_ASSERTIONS
    // A shown result always follows a recorded emission.
    a_emit_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> last_valid_reg)
        else $error("result shown without a recorded emission");

    // A repeated flag means the shown level is the last emitted level.
    a_repeat_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rep_reg) |-> (out_level_reg == last_level_reg))
        else $error("repeated flag disagrees with last emitted level");

    // Ending a window restarts the counter.
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> (count_reg == '0))
        else $error("window counter not cleared after a decision");
`endif

endmodule

// ===== rtl/core/wslc_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration register bank for the sound level classifier.
// Depends on wslc_pkg for register indexes, widths and reset values.
module wslc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wslc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [wslc_pkg::DATA_BITS-1:0] pwdata,
    output logic [wslc_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output wslc_pkg::cfg_t                 cfg
);
    import wslc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    // The register index is the word address.
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length    <= WINDOW_RESET;
            cfg_reg.loud_threshold   <= LOUD_RESET;
            cfg_reg.noisy_threshold  <= NOISY_RESET;
            cfg_reg.normal_threshold <= NORMAL_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_WINDOW: cfg_reg.window_length    <= pwdata[WIN_BITS-1:0];
                REG_LOUD:   cfg_reg.loud_threshold   <= pwdata[THR_BITS-1:0];
                REG_NOISY:  cfg_reg.noisy_threshold  <= pwdata[THR_BITS-1:0];
                REG_NORMAL: cfg_reg.normal_threshold <= pwdata[THR_BITS-1:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (idx)
            REG_WINDOW: prdata = DATA_BITS'(cfg_reg.window_length);
            REG_LOUD:   prdata = DATA_BITS'(cfg_reg.loud_threshold);
            REG_NOISY:  prdata = DATA_BITS'(cfg_reg.noisy_threshold);
            REG_NORMAL: prdata = DATA_BITS'(cfg_reg.normal_threshold);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== sim/wslc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the windowed sound level classifier: follows register traffic, predicts
// the level beats from accepted samples and compares them with the result channel.
// Depends on wslc_pkg only.
module wslc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wslc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [wslc_pkg::DATA_BITS-1:0]   pwdata,
    input  logic [wslc_pkg::DATA_BITS-1:0]   prdata,
    input  logic                             pready,
    input  logic                             sample_valid,
    input  logic                             sample_ready,
    input  logic [wslc_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic [1:0]                       level,
    input  logic                             repeated,
    output int                               fail_count,
    output int                               pending
);
    import wslc_pkg::*;

    typedef struct packed {
        level_t lvl;
        logic   rep;
    } level_beat_t;

    // Local copy of the configuration and of the classifier state.
    cfg_t                cfg;
    logic [WIN_BITS-1:0] window_count;
    logic [BIN_BITS-1:0] bin_count [3];
    level_t              last_emitted;
    logic                emitted_any;
    level_beat_t         expected_beats [$];
    level_beat_t         head_beat;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count = fail_count + 1;
    endtask

    // Add one sample to the bin of its level; bins stop at their maximum.
    task automatic count_in(input level_t lvl);
        if (bin_count[int'(lvl)] != BIN_MAX)
            bin_count[int'(lvl)] = bin_count[int'(lvl)] + 1'b1;
    endtask

    // Advance the window with one sample, queue a level beat if the window ends,
    // then bin the sample by the thresholds in the order loud, noisy, normal.
    task automatic classify_sample(input logic [SAMPLE_BITS-1:0] s);
        level_beat_t         beat;
        logic [BIN_BITS-1:0] best;
        int                  i;
        beat.lvl = LVL_SILENCE;
        beat.rep = 1'b0;
        best     = '0;
        window_count = window_count + 1'b1;
        if (window_count > cfg.window_length)
        begin
            // Scanning from normal up to loud with >= lets the louder level win a tie.
            for (i = 0; i < 3; i++)
            begin
                if (bin_count[i] != '0 && bin_count[i] >= best)
                begin
                    beat.lvl = level_t'(i);
                    best     = bin_count[i];
                end
            end
            beat.rep = emitted_any && (last_emitted == beat.lvl);
            expected_beats.push_back(beat);
            window_count = '0;
            foreach (bin_count[i])
                bin_count[i] = '0;
            last_emitted = beat.lvl;
            emitted_any  = 1'b1;
        end
        if (s <= cfg.loud_threshold)
            count_in(LVL_LOUD);
        else if (s <= cfg.noisy_threshold)
            count_in(LVL_NOISY);
        else if (s <= cfg.normal_threshold)
            count_in(LVL_NORMAL);
    endtask

    // Compare a read beat with the register it addresses, over the register's width.
    task automatic check_read(input reg_idx_t idx, input logic [DATA_BITS-1:0] data);
        logic ok;
        case (idx)
            REG_WINDOW: ok = (data[WIN_BITS-1:0] === cfg.window_length);
            REG_LOUD:   ok = (data[THR_BITS-1:0] === cfg.loud_threshold);
            REG_NOISY:  ok = (data[THR_BITS-1:0] === cfg.noisy_threshold);
            default:    ok = (data[THR_BITS-1:0] === cfg.normal_threshold);
        endcase
        if (!ok)
            report_mismatch($sformatf("register %s read back as 0x%0h", idx.name(), data));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.window_length    = WINDOW_RESET;
            cfg.loud_threshold   = LOUD_RESET;
            cfg.noisy_threshold  = NOISY_RESET;
            cfg.normal_threshold = NORMAL_RESET;
            window_count = '0;
            foreach (bin_count[i])
                bin_count[i] = '0;
            last_emitted = LVL_NORMAL;
            emitted_any  = 1'b0;
            expected_beats.delete();
            pending = 0;
        end
        else
        begin
            // Register port: check reads, then follow writes.
            if (psel && penable && pready && !pwrite)
                check_read(reg_idx_t'(paddr[3:2]), prdata);
            if (psel && penable && pready && pwrite)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_WINDOW: cfg.window_length    = pwdata[WIN_BITS-1:0];
                    REG_LOUD:   cfg.loud_threshold   = pwdata[THR_BITS-1:0];
                    REG_NOISY:  cfg.noisy_threshold  = pwdata[THR_BITS-1:0];
                    default:    cfg.normal_threshold = pwdata[THR_BITS-1:0];
                endcase
            end

            // Predict from every accepted sample beat.
            if (sample_valid && sample_ready)
                classify_sample(sample);

            // Compare every accepted level beat with the oldest prediction.
            if (result_valid && result_ready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch($sformatf("level beat %0d with nothing expected", level));
                else
                begin
                    head_beat = expected_beats.pop_front();
                    if (level !== head_beat.lvl)
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  level, head_beat.lvl));
                    if (repeated !== head_beat.rep)
                        report_mismatch($sformatf("repeated %0b, expected %0b",
                                                  repeated, head_beat.rep));
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the classifier testbench: clock, reset, register writes, sample and result
// handshakes with random idling, and the verdict. Depends on wslc_pkg, wslc_checker
// and windowed_sound_level_classifier_core.
module testbench;
    import wslc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1750;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [ADDR_BITS-1:0]   paddr        = '0;
    logic [DATA_BITS-1:0]   pwdata       = '0;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    logic [SAMPLE_BITS-1:0] sample       = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [1:0]             level;
    logic                   repeated;

    int fail_count;
    int pending;
    int cycles = 0;

    // When set, neither side idles, giving stretches at full rate.
    logic steady = 1'b0;

    // Thresholds currently programmed, used to aim samples at each level.
    int loud_now   = int'(LOUD_RESET);
    int noisy_now  = int'(NOISY_RESET);
    int normal_now = int'(NORMAL_RESET);

    windowed_sound_level_classifier_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .level        (level),
        .repeated     (repeated)
    );

    wslc_checker level_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .level        (level),
        .repeated     (repeated),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (steady)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    // Aim a sample at one of the level bands, at a threshold edge, or anywhere.
    function automatic int pick_sample();
        int lo;
        case ($urandom_range(0, 9))
            0, 1: return $urandom_range(0, 4095);
            2, 3: return $urandom_range(0, loud_now);
            4, 5:
            begin
                lo = (loud_now < 4095) ? loud_now + 1 : 4095;
                return $urandom_range(lo, noisy_now);
            end
            6, 7:
            begin
                lo = (noisy_now < 4095) ? noisy_now + 1 : 4095;
                return $urandom_range(lo, normal_now);
            end
            8:
            begin
                lo = (normal_now < 4095) ? normal_now + 1 : 4095;
                return $urandom_range(lo, 4095);
            end
            default:
            begin
                case ($urandom_range(0, 7))
                    0: return 0;
                    1: return 4095;
                    2: return loud_now;
                    3: return (loud_now + 1) % 4096;
                    4: return noisy_now;
                    5: return (noisy_now + 1) % 4096;
                    6: return normal_now;
                    default: return (normal_now + 1) % 4096;
                endcase
            end
        endcase
    endfunction

    // Present one sample beat after a random gap and hold it until it is taken.
    task automatic send_sample(input int s);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= SAMPLE_BITS'(s);
        do @(posedge clk); while (!sample_ready);
    endtask

    // Stop sending, wait for every predicted beat, then let the pipeline drain.
    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(negedge clk);
    endtask

    // One register access: setup cycle, then access cycle (pready is always high).
    task automatic reg_access(input logic wr, input reg_idx_t idx, input int data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program all four registers, read one back, and pick the idling style.
    task automatic set_config(input int win, input int loud, input int noisy, input int normal);
        reg_access(1'b1, REG_WINDOW, win);
        reg_access(1'b1, REG_LOUD, loud);
        reg_access(1'b1, REG_NOISY, noisy);
        reg_access(1'b1, REG_NORMAL, normal);
        reg_access(1'b0, reg_idx_t'($urandom_range(0, 3)), 0);
        loud_now   = loud;
        noisy_now  = noisy;
        normal_now = normal;
        steady     = ($urandom_range(0, 3) == 0);
    endtask

    // Result side: random stalls before each beat is taken.
    initial
    begin : result_drain
        int stall;
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin : stimulus
        int win;
        int t0;
        int t1;
        int t2;
        int swap;
        int n;
        int sent;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Opening sequence at the reset settings: a three-way tie on the first
        // window, then two silent windows so that silence repeats.
        send_sample(0);
        send_sample(3495);
        send_sample(3496);
        send_sample(3695);
        send_sample(3696);
        send_sample(3895);
        send_sample(3896);
        repeat (13) send_sample(4095);
        send_sample(3600);
        send_sample(3800);
        send_sample(3800);
        send_sample(3000);
        send_sample(2048);

        // Window of zero with all thresholds at zero: every sample ends a window.
        wait_idle();
        set_config(0, 0, 0, 0);
        repeat (60) send_sample(pick_sample());

        // Window length of one with everything counted as loud.
        wait_idle();
        set_config(1, 4095, 4095, 4095);
        repeat (60) send_sample(pick_sample());

        // Longest window that still ends.
        wait_idle();
        set_config(254, 3000, 3400, 3800);
        repeat (520) send_sample(pick_sample());

        // Thresholds in reverse order: the loud test decides first.
        wait_idle();
        set_config(5, 3800, 3400, 3000);
        repeat (100) send_sample(pick_sample());

        // A window that never ends lets the counter wrap and two bins saturate;
        // a short window afterwards shows the saturated tie.
        wait_idle();
        set_config(255, 1000, 2000, 3000);
        repeat (300) send_sample($urandom_range(0, 1000));
        repeat (280) send_sample($urandom_range(1001, 2000));
        wait_idle();
        set_config(3, 1000, 2000, 3000);
        repeat (40) send_sample(pick_sample());

        // Random phases: mostly short windows and ordered thresholds.
        sent = 1385;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       win = 0;
                1:       win = $urandom_range(13, 40);
                default: win = $urandom_range(1, 12);
            endcase
            t0 = $urandom_range(0, 4095);
            t1 = $urandom_range(0, 4095);
            t2 = $urandom_range(0, 4095);
            if ($urandom_range(0, 4) != 0)
            begin
                if (t0 > t1) begin swap = t0; t0 = t1; t1 = swap; end
                if (t1 > t2) begin swap = t1; t1 = t2; t2 = swap; end
                if (t0 > t1) begin swap = t0; t0 = t1; t1 = swap; end
            end
            if ($urandom_range(0, 5) == 0)
            begin
                t0 = int'(LOUD_RESET);
                t1 = int'(NOISY_RESET);
                t2 = int'(NORMAL_RESET);
            end
            wait_idle();
            set_config(win, t0, t1, t2);
            n = $urandom_range(60, 160);
            repeat (n) send_sample(pick_sample());
            sent = sent + n;
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
